// ===== rtl/ftvc_pkg.sv =====
// Shared types, constants and helper functions of the follow-target velocity controller.
// No dependencies; ftvc_cfg_regs, ftvc_muldiv and the core refer to it by scoped names.
package ftvc_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_DIST = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIN     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANG     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_GAIN   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAR_GAIN   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RATE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TMO  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_GAIN   = 4'd7;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_FOLLOW = 2'd2;

  typedef struct packed {
    logic [13:0] follow_distance_mm;
    logic [11:0] max_linear_mmps;
    logic [12:0] max_angular_mradps;
    logic [13:0] distance_gain_milli;
    logic [13:0] bearing_gain_milli;
    logic [12:0] search_rate_mradps;
    logic [7:0]  search_tmo_sec;
    logic [13:0] heading_gain_milli;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_MILLI,
    DIV_HALF_PI,
    DIV_MEGA
  } div_sel_t;

  typedef struct packed {
    logic [20:0] a;
    logic [20:0] b;
    logic        neg;
    div_sel_t    dsel;
  } md_req_t;

  localparam logic [20:0] MILLI        = 21'd1000;
  localparam logic [20:0] HALF_PI_URAD = 21'd1570796;
  localparam logic [20:0] MEGA         = 21'd1000000;

  // Reciprocals are floor(2^34 / divisor). For products below 2^34 the estimate is
  // at most one below the true quotient, so one compare and add finishes it.
  localparam logic [24:0] RCP_MILLI   = 25'd17179869;
  localparam logic [24:0] RCP_HALF_PI = 25'd10937;
  localparam logic [24:0] RCP_MEGA    = 25'd17179;

  localparam logic [31:0] LOST_HOLD_US = 32'd500000;
  localparam logic [20:0] LIN_ACCEL    = 21'd800;
  localparam logic [20:0] LIN_DECEL    = 21'd2000;
  localparam logic [20:0] ANG_ACCEL    = 21'd6000;

  localparam logic signed [15:0] PI_FLOOR = 16'sd3141;
  localparam logic signed [15:0] TWO_PI   = 16'sd6283;

  // Maps an angle into [-3141, 3141] modulo 6283; inputs stay within three turns.
  function automatic logic signed [15:0] wrap_mrad(input logic signed [15:0] a);
    logic signed [15:0] r;
    r = a;
    for (int i = 0; i < 3; i++) begin
      if (r > PI_FLOOR) begin
        r = r - TWO_PI;
      end else if (r < -PI_FLOOR) begin
        r = r + TWO_PI;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/ftvc_ifs.sv =====
// Valid/ready channel interfaces of the controller: tick input, command output, register writes.
// Depends on nothing.
interface ftvc_tick_if;
  logic               valid;
  logic               ready;
  logic [19:0]        tick_us;
  logic               target_valid;
  logic [15:0]        target_distance_mm;
  logic signed [12:0] target_bearing_mrad;
  logic               yaw_valid;
  logic signed [12:0] yaw_mrad;
  modport source(output valid, tick_us, target_valid, target_distance_mm,
                 target_bearing_mrad, yaw_valid, yaw_mrad, input ready);
  modport sink(input valid, tick_us, target_valid, target_distance_mm,
               target_bearing_mrad, yaw_valid, yaw_mrad, output ready);
endinterface

interface ftvc_cmd_if;
  logic               valid;
  logic               ready;
  logic [11:0]        linear_cmd_mmps;
  logic signed [13:0] angular_cmd_mradps;
  logic [1:0]         mode;
  modport source(output valid, linear_cmd_mmps, angular_cmd_mradps, mode, input ready);
  modport sink(input valid, linear_cmd_mmps, angular_cmd_mradps, mode, output ready);
endinterface

interface ftvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/ftvc_cfg_regs.sv =====
// Configuration register file: reset values, width masking and index decode.
// Depends on ftvc_pkg and ftvc_cfg_if.
module ftvc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  ftvc_cfg_if.sink      cfg,
  output ftvc_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.follow_distance_mm  <= 14'd1500;
      regs.max_linear_mmps     <= 12'd1000;
      regs.max_angular_mradps  <= 13'd1500;
      regs.distance_gain_milli <= 14'd1000;
      regs.bearing_gain_milli  <= 14'd1500;
      regs.search_rate_mradps  <= 13'd800;
      regs.search_tmo_sec      <= 8'd10;
      regs.heading_gain_milli  <= 14'd2000;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ftvc_pkg::CFG_FOLLOW_DIST: regs.follow_distance_mm  <= cfg.data[13:0];
        ftvc_pkg::CFG_MAX_LIN:     regs.max_linear_mmps     <= cfg.data[11:0];
        ftvc_pkg::CFG_MAX_ANG:     regs.max_angular_mradps  <= cfg.data[12:0];
        ftvc_pkg::CFG_DIST_GAIN:   regs.distance_gain_milli <= cfg.data[13:0];
        ftvc_pkg::CFG_BEAR_GAIN:   regs.bearing_gain_milli  <= cfg.data[13:0];
        ftvc_pkg::CFG_SEARCH_RATE: regs.search_rate_mradps  <= cfg.data[12:0];
        ftvc_pkg::CFG_SEARCH_TMO:  regs.search_tmo_sec      <= cfg.data[7:0];
        ftvc_pkg::CFG_HEAD_GAIN:   regs.heading_gain_milli  <= cfg.data[13:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ftvc_muldiv.sv =====
// Shared multiply-then-divide unit: one multiplier used for the product, a reciprocal
// multiply by the selected constant and a back-multiply for the final correction.
// Depends on ftvc_pkg.
module ftvc_muldiv (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ftvc_pkg::md_req_t  req,
  output logic               done,
  output logic signed [23:0] result
);

  typedef enum logic [2:0] {MD_IDLE, MD_PROD, MD_RECIP, MD_BACK, MD_FIX} md_state_t;

  md_state_t   st;
  logic [20:0] opa;
  logic [20:0] opb;
  logic [20:0] dvs;
  logic [24:0] rcp;
  logic        neg;
  logic [33:0] num;
  logic [24:0] quo;
  logic [21:0] rem;

  logic [34:0] mul_x;
  logic [24:0] mul_y;
  logic [59:0] mul_p;
  logic [34:0] back_diff;
  logic [24:0] quo_fix;

  always_comb begin
    unique case (st)
      MD_RECIP: begin
        mul_x = {1'b0, num};
        mul_y = rcp;
      end
      MD_BACK: begin
        mul_x = 35'(dvs);
        mul_y = quo;
      end
      default: begin
        mul_x = 35'(opa);
        mul_y = 25'(opb);
      end
    endcase
    mul_p     = 60'(mul_x) * 60'(mul_y);
    back_diff = {1'b0, num} - mul_p[34:0];
    quo_fix   = (rem >= {1'b0, dvs}) ? quo + 25'd1 : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= MD_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        MD_IDLE: begin
          if (start) begin
            opa <= req.a;
            opb <= req.b;
            neg <= req.neg;
            unique case (req.dsel)
              ftvc_pkg::DIV_MILLI: begin
                dvs <= ftvc_pkg::MILLI;
                rcp <= ftvc_pkg::RCP_MILLI;
              end
              ftvc_pkg::DIV_HALF_PI: begin
                dvs <= ftvc_pkg::HALF_PI_URAD;
                rcp <= ftvc_pkg::RCP_HALF_PI;
              end
              default: begin
                dvs <= ftvc_pkg::MEGA;
                rcp <= ftvc_pkg::RCP_MEGA;
              end
            endcase
            st <= MD_PROD;
          end
        end
        MD_PROD: begin
          num <= mul_p[33:0];
          st  <= MD_RECIP;
        end
        MD_RECIP: begin
          quo <= mul_p[58:34];
          st  <= MD_BACK;
        end
        MD_BACK: begin
          rem <= back_diff[21:0];
          st  <= MD_FIX;
        end
        MD_FIX: begin
          result <= neg ? 24'(0) - 24'(quo_fix[22:0]) : 24'(quo_fix[22:0]);
          done   <= 1'b1;
          st     <= MD_IDLE;
        end
        default: st <= MD_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/follow_target_velocity_controller_core.sv =====
// Top level of the follow-target velocity controller: sequencer, controller state, output register.
// Depends on ftvc_pkg, ftvc_ifs, ftvc_cfg_regs and ftvc_muldiv.
//
//   channel  direction  beat contents
//   tick     in         tick_us, target flag/range/bearing, yaw flag/yaw
//   cmd      out        linear_cmd_mmps, angular_cmd_mradps, mode
//   cfg      in         index, data (register write, always ready)
//
// One tick issues up to seven multiply-divides on the shared unit, and none when the
// target is absent and the tick is zero.
// tick.ready is high only while the sequencer is idle. A finished beat waits in the
// output register; the next tick is taken meanwhile and holds only at its end.
// Synchronous reset restores the register defaults and the idle controller state.
module follow_target_velocity_controller_core (
  input  logic       clk,
  input  logic       rst,
  ftvc_tick_if.sink  tick,
  ftvc_cmd_if.source cmd,
  ftvc_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_OP_VDES, S_OP_WDES, S_OP_SCALE, S_OP_HEAD,
    S_OP_CORR, S_RAMP, S_OP_LSTEP, S_OP_ASTEP, S_SEND
  } state_t;

  ftvc_pkg::cfg_t    regs;
  ftvc_pkg::md_req_t md_req;
  logic              md_start;
  logic              md_done;
  logic signed [23:0] md_res;

  state_t state;
  logic   issued;
  logic   out_valid;

  logic [19:0]        dt;
  logic               tv;
  logic [15:0]        dist_mm;
  logic signed [12:0] bear;
  logic               yv;
  logic signed [12:0] yaw;

  logic [1:0]         mode;
  logic [11:0]        lin;
  logic signed [13:0] ang;
  logic [31:0]        lost;
  logic [31:0]        search;
  logic               last_left;
  logic               has_seen;
  logic signed [12:0] href;
  logic               href_set;
  logic [11:0]        v;
  logic signed [13:0] w;

  logic [32:0]        lost_sum;
  logic [32:0]        search_sum;
  logic [31:0]        lost_n;
  logic [31:0]        search_n;
  logic [27:0]        search_limit;
  logic signed [16:0] err;
  logic [12:0]        bear_mag;
  logic [22:0]        bear_k;
  logic [20:0]        scale_pos;
  logic signed [15:0] eyaw;
  logic [11:0]        eyaw_mag;
  logic signed [15:0] href_sum;
  logic signed [23:0] maxw_s;
  logic signed [23:0] w_src;
  logic signed [13:0] w_clamped;
  logic signed [23:0] v_res_clamp_hi;
  logic signed [13:0] ldiff;
  logic signed [13:0] lstep;
  logic [11:0]        lin_new;
  logic signed [15:0] adiff;
  logic signed [15:0] astep;
  logic signed [13:0] ang_new;
  logic               op_state;

  ftvc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ftvc_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .req    (md_req),
    .done   (md_done),
    .result (md_res)
  );

  assign tick.ready             = (state == S_IDLE);
  assign cmd.valid              = out_valid;

  always_comb begin
    lost_sum     = {1'b0, lost} + 33'(dt);
    search_sum   = {1'b0, search} + 33'(dt);
    lost_n       = lost_sum[32] ? 32'hFFFF_FFFF : lost_sum[31:0];
    search_n     = (mode == ftvc_pkg::MODE_SEARCH) ?
                   (search_sum[32] ? 32'hFFFF_FFFF : search_sum[31:0]) : search;
    search_limit = 28'(regs.search_tmo_sec) * 28'(ftvc_pkg::MEGA);
    err          = signed'({1'b0, dist_mm}) - signed'({3'b0, regs.follow_distance_mm});
    bear_mag     = bear[12] ? 13'(~bear + 13'sd1) : 13'(bear);
    bear_k       = 23'(bear_mag) * 23'd1000;
    scale_pos    = (bear_k < 23'(ftvc_pkg::HALF_PI_URAD)) ?
                   21'(23'(ftvc_pkg::HALF_PI_URAD) - bear_k) : 21'd0;
    eyaw         = ftvc_pkg::wrap_mrad(16'(href) - 16'(yaw));
    eyaw_mag     = eyaw[15] ? 12'(-eyaw) : 12'(eyaw);
    href_sum     = 16'(href) + md_res[15:0];
    maxw_s       = signed'({11'b0, regs.max_angular_mradps});
    v_res_clamp_hi = signed'({12'b0, regs.max_linear_mmps});

    w_src = (state == S_OP_CORR) ? md_res + 24'(w) : md_res;
    if (w_src > maxw_s) begin
      w_clamped = 14'(maxw_s);
    end else if (w_src < -maxw_s) begin
      w_clamped = 14'(-maxw_s);
    end else begin
      w_clamped = w_src[13:0];
    end

    ldiff = signed'({2'b0, v}) - signed'({2'b0, lin});
    lstep = signed'({1'b0, md_res[12:0]});
    if (ldiff > lstep) begin
      lin_new = 12'(signed'({2'b0, lin}) + lstep);
    end else if (ldiff < -lstep) begin
      lin_new = 12'(signed'({2'b0, lin}) - lstep);
    end else begin
      lin_new = v;
    end

    adiff = 16'(w) - 16'(ang);
    astep = md_res[15:0];
    if (adiff > astep) begin
      ang_new = 14'(16'(ang) + astep);
    end else if (adiff < -astep) begin
      ang_new = 14'(16'(ang) - astep);
    end else begin
      ang_new = w;
    end

    md_req = '{a: '0, b: '0, neg: 1'b0, dsel: ftvc_pkg::DIV_MILLI};
    unique case (state)
      S_OP_VDES: begin
        md_req.a = 21'(regs.distance_gain_milli);
        md_req.b = 21'(err[15:0]);
      end
      S_OP_WDES: begin
        md_req.a   = 21'(regs.bearing_gain_milli);
        md_req.b   = 21'(bear_mag);
        md_req.neg = bear[12];
      end
      S_OP_SCALE: begin
        md_req.a    = 21'(v);
        md_req.b    = scale_pos;
        md_req.dsel = ftvc_pkg::DIV_HALF_PI;
      end
      S_OP_HEAD: begin
        md_req.a    = w[13] ? 21'(-16'(w)) : 21'(w);
        md_req.b    = 21'(dt);
        md_req.neg  = w[13];
        md_req.dsel = ftvc_pkg::DIV_MEGA;
      end
      S_OP_CORR: begin
        md_req.a   = 21'(regs.heading_gain_milli);
        md_req.b   = 21'(eyaw_mag);
        md_req.neg = eyaw[15];
      end
      S_OP_LSTEP: begin
        md_req.a    = (v >= lin) ? ftvc_pkg::LIN_ACCEL : ftvc_pkg::LIN_DECEL;
        md_req.b    = 21'(dt);
        md_req.dsel = ftvc_pkg::DIV_MEGA;
      end
      S_OP_ASTEP: begin
        md_req.a    = ftvc_pkg::ANG_ACCEL;
        md_req.b    = 21'(dt);
        md_req.dsel = ftvc_pkg::DIV_MEGA;
      end
      default: ;
    endcase

    op_state = (state == S_OP_VDES) || (state == S_OP_WDES) || (state == S_OP_SCALE) ||
               (state == S_OP_HEAD) || (state == S_OP_CORR) || (state == S_OP_LSTEP) ||
               (state == S_OP_ASTEP);
    md_start = op_state && !issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      mode      <= ftvc_pkg::MODE_IDLE;
      lin       <= '0;
      ang       <= '0;
      lost      <= '0;
      search    <= '0;
      last_left <= 1'b1;
      has_seen  <= 1'b0;
      href      <= '0;
      href_set  <= 1'b0;
    end else begin
      if (md_start) begin
        issued <= 1'b1;
      end else if (md_done) begin
        issued <= 1'b0;
      end
      if (cmd.ready && (state != S_SEND)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            dt      <= tick.tick_us;
            tv      <= tick.target_valid;
            dist_mm <= tick.target_distance_mm;
            bear    <= tick.target_bearing_mrad;
            yv      <= tick.yaw_valid;
            yaw     <= tick.yaw_mrad;
            state   <= S_START;
          end
        end
        S_START: begin
          if (tv) begin
            lost      <= '0;
            search    <= '0;
            last_left <= !bear[12];
            has_seen  <= 1'b1;
            mode      <= ftvc_pkg::MODE_FOLLOW;
            if (err > 17'sd0) begin
              state <= S_OP_VDES;
            end else begin
              v     <= '0;
              state <= S_OP_WDES;
            end
          end else begin
            lost   <= lost_n;
            search <= search_n;
            v      <= '0;
            state  <= S_RAMP;
            if (lost_n > ftvc_pkg::LOST_HOLD_US) begin
              href_set <= 1'b0;
              if (has_seen && (search_n <= 32'(search_limit))) begin
                mode <= ftvc_pkg::MODE_SEARCH;
                w    <= last_left ? signed'({1'b0, regs.search_rate_mradps}) :
                        -signed'({1'b0, regs.search_rate_mradps});
              end else begin
                mode     <= ftvc_pkg::MODE_IDLE;
                has_seen <= 1'b0;
                w        <= '0;
              end
            end else begin
              w <= '0;
            end
          end
        end
        S_OP_VDES: begin
          if (md_done) begin
            v     <= (md_res > v_res_clamp_hi) ? regs.max_linear_mmps : md_res[11:0];
            state <= S_OP_WDES;
          end
        end
        S_OP_WDES: begin
          if (md_done) begin
            w     <= w_clamped;
            state <= S_OP_SCALE;
          end
        end
        S_OP_SCALE: begin
          if (md_done) begin
            v <= md_res[11:0];
            if (yv) begin
              if (!href_set) begin
                href     <= yaw;
                href_set <= 1'b1;
              end
              state <= S_OP_HEAD;
            end else begin
              href_set <= 1'b0;
              state    <= S_RAMP;
            end
          end
        end
        S_OP_HEAD: begin
          if (md_done) begin
            href  <= 13'(ftvc_pkg::wrap_mrad(href_sum));
            state <= S_OP_CORR;
          end
        end
        S_OP_CORR: begin
          if (md_done) begin
            w     <= w_clamped;
            state <= S_RAMP;
          end
        end
        S_RAMP: begin
          if (dt == 20'd0) begin
            lin   <= v;
            ang   <= w;
            state <= S_SEND;
          end else begin
            state <= S_OP_LSTEP;
          end
        end
        S_OP_LSTEP: begin
          if (md_done) begin
            lin   <= lin_new;
            state <= S_OP_ASTEP;
          end
        end
        S_OP_ASTEP: begin
          if (md_done) begin
            ang   <= ang_new;
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (!out_valid || cmd.ready) begin
            cmd.linear_cmd_mmps    <= lin;
            cmd.angular_cmd_mradps <= ang;
            cmd.mode               <= mode;
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
